// File: rtl/hot_row_frequency_tracker_assert.svh
// Assertion macros for the hot row frequency tracker.
// Needs a clock and an active-low reset passed in by the caller.
`ifndef HOT_ROW_FREQUENCY_TRACKER_ASSERT_SVH
`define HOT_ROW_FREQUENCY_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HRFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hrft_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed field widths of the hot row frequency tracker.
// No dependencies.
package hrft_pkg;

  localparam int unsigned VaultW   = 4;
  localparam int unsigned BankFldW = 3;
  localparam int unsigned RowW     = 13;
  localparam int unsigned CntW     = 16;
  localparam int unsigned SmallW   = 4;

  localparam logic [CntW-1:0]   CountMax   = '1;
  localparam logic [SmallW-1:0] LimitReset = 4'd8;

  typedef struct packed {
    logic            valid;
    logic [RowW-1:0] row;
    logic [CntW-1:0] count;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef struct packed {
    logic              hit;
    logic              inserted;
    logic [CntW-1:0]   row_count;
    logic [SmallW-1:0] removed;
    logic [SmallW-1:0] occupancy;
  } result_t;

endpackage

// File: rtl/hrft_ram.sv
`timescale 1ns / 1ps
// Generic two-port RAM with one write port and one registered read port.
// No dependencies.
module hrft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/hrft_queue.sv
`timescale 1ns / 1ps
// Short FIFO that decouples the front classifier from the table update engine.
// No dependencies.
module hrft_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));

endmodule

// File: rtl/hrft_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, checks the bank and row ranges and forms the flat bank index.
// Depends on hrft_pkg.
module hrft_front #(
  parameter int unsigned NUM_VAULTS      = 16,
  parameter int unsigned BANKS_PER_VAULT = 8,
  parameter int unsigned ROWS_PER_BANK   = 8192,
  parameter int unsigned ITEM_W          = 21
) (
  input  logic                          start_i,
  input  logic                          full_i,
  input  logic [hrft_pkg::VaultW-1:0]   vault_i,
  input  logic [hrft_pkg::BankFldW-1:0] bank_i,
  input  logic [hrft_pkg::RowW-1:0]     row_i,
  output logic                          push_o,
  output logic [ITEM_W-1:0]             item_o
);
  import hrft_pkg::*;

  localparam int unsigned BankIdxW = ITEM_W - 1 - RowW;

  logic        in_range;
  logic [31:0] flat_idx;

  assign in_range = (32'(vault_i) < NUM_VAULTS) && (32'(bank_i) < BANKS_PER_VAULT)
                 && (32'(row_i) < ROWS_PER_BANK);
  assign flat_idx = 32'(vault_i) * BANKS_PER_VAULT + 32'(bank_i);

  assign push_o = start_i && !full_i;
  assign item_o = {!in_range, flat_idx[BankIdxW-1:0], row_i};

endmodule

// File: rtl/hrft_back.sv
`timescale 1ns / 1ps
// Back end: read-modify-write of one bank's Misra-Gries table word per item.
// Depends on hrft_pkg and hrft_ram.
module hrft_back #(
  parameter int unsigned NUM_VAULTS      = 16,
  parameter int unsigned BANKS_PER_VAULT = 8,
  parameter int unsigned MAX_TRACKED     = 8,
  parameter int unsigned ITEM_W          = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hrft_pkg::SmallW-1:0] limit_i,
  input  logic                        empty_i,
  input  logic [ITEM_W-1:0]           item_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  output hrft_pkg::result_t           res_o
);
  import hrft_pkg::*;

  localparam int unsigned TotalBanks = NUM_VAULTS * BANKS_PER_VAULT;
  localparam int unsigned BankIdxW   = ITEM_W - 1 - RowW;
  localparam int unsigned WordW      = MAX_TRACKED * SlotW;
  localparam int unsigned OccW       = $clog2(MAX_TRACKED + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic                  ignore_q;
  logic [BankIdxW-1:0]   idx_q;
  logic [RowW-1:0]       row_q;
  logic                  fresh_q;
  logic [TotalBanks-1:0] bank_vld_q;

  logic                  wr_en;
  logic [WordW-1:0]      rd_data;
  logic [WordW-1:0]      wr_data;

  slot_t                 cur   [MAX_TRACKED];
  slot_t                 nxt   [MAX_TRACKED];
  logic [MAX_TRACKED-1:0] vmask, match, first_free, drop;
  logic [OccW-1:0]       occ, limit_eff, removed, occ_new;
  logic [CntW-1:0]       hit_cnt, dec_cnt;
  logic                  found, do_ins;
  result_t               res;

  hrft_ram #(
    .WIDTH(WordW),
    .DEPTH(TotalBanks)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(idx_q),
    .wr_data_i(wr_data),
    .rd_en_i  (pop_o),
    .rd_addr_i(item_i[RowW +: BankIdxW]),
    .rd_data_o(rd_data)
  );

  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign wr_en = (state_q == ST_EXEC) && !ignore_q;

  always_comb begin
    for (int i = 0; i < MAX_TRACKED; i++) begin
      cur[i]   = fresh_q ? slot_t'(rd_data[i*SlotW +: SlotW]) : '0;
      vmask[i] = cur[i].valid;
      match[i] = cur[i].valid && (cur[i].row == row_q);
    end
  end

  always_comb begin
    first_free = ~vmask & (vmask + 1'b1);
    occ        = OccW'($countones(vmask));
    limit_eff  = (32'(limit_i) > MAX_TRACKED) ? OccW'(MAX_TRACKED) : OccW'(limit_i);
    found      = |match;
    do_ins     = !found && (occ < limit_eff) && (|first_free);
    hit_cnt    = '0;
    drop       = '0;
    dec_cnt    = '0;
    for (int i = 0; i < MAX_TRACKED; i++) begin
      nxt[i] = cur[i];
      if (found) begin
        if (match[i]) begin
          nxt[i].count = (cur[i].count != CountMax) ? cur[i].count + 1'b1 : cur[i].count;
          hit_cnt      = hit_cnt | nxt[i].count;
        end
      end else if (do_ins) begin
        if (first_free[i]) begin
          nxt[i].valid = 1'b1;
          nxt[i].row   = row_q;
          nxt[i].count = CntW'(1);
        end
      end else if (cur[i].valid) begin
        dec_cnt      = (cur[i].count != '0) ? cur[i].count - 1'b1 : cur[i].count;
        nxt[i].count = dec_cnt;
        if (dec_cnt == '0) begin
          nxt[i].valid = 1'b0;
          drop[i]      = 1'b1;
        end
      end
      wr_data[i*SlotW +: SlotW] = nxt[i];
    end
    removed = OccW'($countones(drop));
    if (found) begin
      occ_new = occ;
    end else if (do_ins) begin
      occ_new = occ + 1'b1;
    end else begin
      occ_new = occ - removed;
    end
    res.hit       = found;
    res.inserted  = do_ins;
    res.row_count = found ? hit_cnt : (do_ins ? CntW'(1) : '0);
    res.removed   = SmallW'(removed);
    res.occupancy = SmallW'(occ_new);
  end

  assign res_valid_o = (state_q == ST_EXEC);
  assign res_o       = ignore_q ? '0 : res;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bank_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        bank_vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ignore_q <= item_i[ITEM_W-1];
      idx_q    <= item_i[RowW +: BankIdxW];
      row_q    <= item_i[RowW-1:0];
      fresh_q  <= bank_vld_q[item_i[RowW +: BankIdxW]];
    end
  end

endmodule

// File: rtl/hot_row_frequency_tracker.sv
`timescale 1ns / 1ps
// Top level of the hot row frequency tracker: per-bank Misra-Gries row tables.
// Depends on hrft_pkg, hrft_front, hrft_queue, hrft_back and the assertion header.
//
// Usage:
// An access is taken at a rising edge where start is high and busy is low.
// vault_i, bank_i and row_i select the bank table and the accessed row.
// Each access produces exactly one result, shown for one cycle with
// result_valid_o high; the receiver must take it then, it cannot stall.
// An access to a bank or row outside the configured ranges returns all zeros.
// An accepted access passes through the queue, the table RAM read and the
// result register before the result strobe. The engine takes no new access
// until the read-modify-write of the bank's table word in the RAM is done.
// A two-entry queue holds accepted accesses; busy is high while it is full.
// tracked_limit_i is written through cfg_valid_i and cfg_ready_o, which is
// always high; write it only while no access is in flight.
// Reset empties every bank table at once through per-bank valid flags, so
// no clearing pass is needed, and sets the limit to eight.
`include "hot_row_frequency_tracker_assert.svh"
module hot_row_frequency_tracker #(
  parameter int unsigned NUM_VAULTS      = 16,
  parameter int unsigned BANKS_PER_VAULT = 8,
  parameter int unsigned MAX_TRACKED     = 8,
  parameter int unsigned ROWS_PER_BANK   = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [hrft_pkg::VaultW-1:0]   vault_i,
  input  logic [hrft_pkg::BankFldW-1:0] bank_i,
  input  logic [hrft_pkg::RowW-1:0]     row_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic                          inserted_o,
  output logic [hrft_pkg::CntW-1:0]     row_count_o,
  output logic [hrft_pkg::SmallW-1:0]   removed_o,
  output logic [hrft_pkg::SmallW-1:0]   occupancy_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hrft_pkg::SmallW-1:0]   tracked_limit_i
);
  import hrft_pkg::*;

  localparam int unsigned TotalBanks = NUM_VAULTS * BANKS_PER_VAULT;
  localparam int unsigned BankIdxW   = (TotalBanks > 1) ? $clog2(TotalBanks) : 1;
  localparam int unsigned ItemW      = 1 + BankIdxW + RowW;

  logic [SmallW-1:0] limit_q;
  logic              push, pop, q_empty, q_full;
  logic [ItemW-1:0]  push_item, head_item;
  logic              res_valid;
  result_t           res;
  logic              res_valid_q;
  result_t           res_q;

  hrft_front #(
    .NUM_VAULTS     (NUM_VAULTS),
    .BANKS_PER_VAULT(BANKS_PER_VAULT),
    .ROWS_PER_BANK  (ROWS_PER_BANK),
    .ITEM_W         (ItemW)
  ) u_front (
    .start_i(start),
    .full_i (q_full),
    .vault_i(vault_i),
    .bank_i (bank_i),
    .row_i  (row_i),
    .push_o (push),
    .item_o (push_item)
  );

  hrft_queue #(
    .WIDTH(ItemW),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_item),
    .pop_i  (pop),
    .data_o (head_item),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  hrft_back #(
    .NUM_VAULTS     (NUM_VAULTS),
    .BANKS_PER_VAULT(BANKS_PER_VAULT),
    .MAX_TRACKED    (MAX_TRACKED),
    .ITEM_W         (ItemW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .empty_i    (q_empty),
    .item_i     (head_item),
    .pop_o      (pop),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= tracked_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign busy           = q_full;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign hit_o          = res_q.hit;
  assign inserted_o     = res_q.inserted;
  assign row_count_o    = res_q.row_count;
  assign removed_o      = res_q.removed;
  assign occupancy_o    = res_q.occupancy;

  `HRFT_ASSERT_NEXT(a_strobe_gap, clk_i, rst_ni, result_valid_o, !result_valid_o, "result strobe in two adjacent cycles")
  `HRFT_ASSERT_NOW(a_hit_ins_excl, clk_i, rst_ni, result_valid_o, !(hit_o && inserted_o), "hit and inserted both set")
  `HRFT_ASSERT_NOW(a_hit_count, clk_i, rst_ni, result_valid_o && hit_o, row_count_o != '0, "hit with zero count")
  `HRFT_ASSERT_NOW(a_ins_count, clk_i, rst_ni, result_valid_o && inserted_o, (row_count_o == CntW'(1)) && (occupancy_o != '0), "insert result inconsistent")

endmodule

// File: tb/sv/hrft_checker.sv
`timescale 1ns / 1ps
// Checker for the hot row frequency tracker: watches the access, result and limit channels.
// It keeps its own copy of every bank's row table and compares each result in order.
// Depends on hrft_pkg.
module hrft_checker #(
  parameter int unsigned NUM_VAULTS      = 16,
  parameter int unsigned BANKS_PER_VAULT = 8,
  parameter int unsigned MAX_TRACKED     = 8,
  parameter int unsigned ROWS_PER_BANK   = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [hrft_pkg::VaultW-1:0]   vault_i,
  input  logic [hrft_pkg::BankFldW-1:0] bank_i,
  input  logic [hrft_pkg::RowW-1:0]     row_i,
  input  logic                          result_valid_i,
  input  logic                          hit_i,
  input  logic                          inserted_i,
  input  logic [hrft_pkg::CntW-1:0]     row_count_i,
  input  logic [hrft_pkg::SmallW-1:0]   removed_i,
  input  logic [hrft_pkg::SmallW-1:0]   occupancy_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [hrft_pkg::SmallW-1:0]   tracked_limit_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);
  import hrft_pkg::*;

  localparam int unsigned NumBanks = NUM_VAULTS * BANKS_PER_VAULT;

  logic              slot_valid [NumBanks][MAX_TRACKED];
  logic [RowW-1:0]   slot_row   [NumBanks][MAX_TRACKED];
  logic [CntW-1:0]   slot_count [NumBanks][MAX_TRACKED];
  logic [SmallW-1:0] limit_q;
  result_t           pending_outcomes [$];

  function automatic result_t predict_access(input logic [VaultW-1:0] vault,
                                             input logic [BankFldW-1:0] bank,
                                             input logic [RowW-1:0] row);
    result_t     res;
    int unsigned id;
    int unsigned occ;
    int unsigned lim;
    int          found;
    int          free_slot;
    res = '0;
    lim = (limit_q > MAX_TRACKED) ? MAX_TRACKED : limit_q;
    if (vault >= NUM_VAULTS || bank >= BANKS_PER_VAULT || row >= ROWS_PER_BANK) begin
      return res;
    end
    id = vault * BANKS_PER_VAULT + bank;
    found = -1;
    free_slot = -1;
    occ = 0;
    for (int i = 0; i < MAX_TRACKED; i++) begin
      if (slot_valid[id][i]) begin
        occ++;
        if (found < 0 && slot_row[id][i] == row) begin
          found = i;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (slot_count[id][found] != CountMax) begin
        slot_count[id][found] = slot_count[id][found] + 1'b1;
      end
      res.row_count = slot_count[id][found];
    end else if (occ < lim && free_slot >= 0) begin
      res.inserted = 1'b1;
      slot_valid[id][free_slot] = 1'b1;
      slot_row[id][free_slot] = row;
      slot_count[id][free_slot] = CntW'(1);
      res.row_count = CntW'(1);
      occ++;
    end else begin
      // A miss on a table at its limit ages every entry and drops those that run out.
      for (int i = 0; i < MAX_TRACKED; i++) begin
        if (slot_valid[id][i]) begin
          if (slot_count[id][i] != 0) begin
            slot_count[id][i] = slot_count[id][i] - 1'b1;
          end
          if (slot_count[id][i] == 0) begin
            slot_valid[id][i] = 1'b0;
            res.removed = res.removed + 1'b1;
            occ--;
          end
        end
      end
    end
    res.occupancy = SmallW'(occ);
    return res;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  initial begin
    mismatch_count_o = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      foreach (slot_valid[b, s]) begin
        slot_valid[b][s] = 1'b0;
        slot_row[b][s] = '0;
        slot_count[b][s] = '0;
      end
      limit_q = LimitReset;
      pending_outcomes.delete();
    end else begin
      if (result_valid_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with no access outstanding, actual hit %0d inserted %0d",
                   $time, hit_i, inserted_i);
          mismatch_count_o++;
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("hit", want.hit, hit_i);
          compare_field("inserted", want.inserted, inserted_i);
          compare_field("row_count", want.row_count, row_count_i);
          compare_field("removed", want.removed, removed_i);
          compare_field("occupancy", want.occupancy, occupancy_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        limit_q = tracked_limit_i;
      end
      if (start_i && !busy_i) begin
        pending_outcomes.insert(pending_outcomes.size(),
                                predict_access(vault_i, bank_i, row_i));
      end
    end
    outstanding_o = pending_outcomes.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the hot row frequency tracker testbench: clock, reset, access stimulus and verdict.
// Depends on hrft_pkg, hot_row_frequency_tracker and hrft_checker.
module testbench;
  import hrft_pkg::*;

  localparam int unsigned NUM_VAULTS      = 16;
  localparam int unsigned BANKS_PER_VAULT = 8;
  localparam int unsigned MAX_TRACKED     = 8;
  localparam int unsigned ROWS_PER_BANK   = 8192;
  localparam int unsigned PhaseItems      = 470;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [VaultW-1:0]   vault_i;
  logic [BankFldW-1:0] bank_i;
  logic [RowW-1:0]     row_i;
  logic                result_valid_o;
  logic                hit_o;
  logic                inserted_o;
  logic [CntW-1:0]     row_count_o;
  logic [SmallW-1:0]   removed_o;
  logic [SmallW-1:0]   occupancy_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SmallW-1:0]   tracked_limit_i;
  int                  mismatches;
  int                  outstanding;
  int unsigned         sender_idle_pct;

  always #1 clk_i = ~clk_i;

  hot_row_frequency_tracker #(
    .NUM_VAULTS(NUM_VAULTS),
    .BANKS_PER_VAULT(BANKS_PER_VAULT),
    .MAX_TRACKED(MAX_TRACKED),
    .ROWS_PER_BANK(ROWS_PER_BANK)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .vault_i(vault_i),
    .bank_i(bank_i),
    .row_i(row_i),
    .result_valid_o(result_valid_o),
    .hit_o(hit_o),
    .inserted_o(inserted_o),
    .row_count_o(row_count_o),
    .removed_o(removed_o),
    .occupancy_o(occupancy_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .tracked_limit_i(tracked_limit_i)
  );

  hrft_checker #(
    .NUM_VAULTS(NUM_VAULTS),
    .BANKS_PER_VAULT(BANKS_PER_VAULT),
    .MAX_TRACKED(MAX_TRACKED),
    .ROWS_PER_BANK(ROWS_PER_BANK)
  ) checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_i(busy),
    .vault_i(vault_i),
    .bank_i(bank_i),
    .row_i(row_i),
    .result_valid_i(result_valid_o),
    .hit_i(hit_o),
    .inserted_i(inserted_o),
    .row_count_i(row_count_o),
    .removed_i(removed_o),
    .occupancy_i(occupancy_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .tracked_limit_i(tracked_limit_i),
    .mismatch_count_o(mismatches),
    .outstanding_o(outstanding)
  );

  task automatic send_access(input logic [VaultW-1:0] v, input logic [BankFldW-1:0] b,
                             input logic [RowW-1:0] r);
    @(negedge clk_i);
    start <= 1'b1;
    vault_i <= v;
    bank_i <= b;
    row_i <= r;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      vault_i <= VaultW'($urandom);
      bank_i <= BankFldW'($urandom);
      row_i <= RowW'($urandom);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [SmallW-1:0] lim);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    tracked_limit_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Most items hit a few hot rows of two banks so tables fill, age and refill;
  // the rest are spread over the whole address space.
  task automatic run_phase(input int unsigned idle_pct, input logic [SmallW-1:0] lim);
    logic [VaultW-1:0]   hot_vault;
    logic [BankFldW-1:0] hot_bank_a;
    logic [BankFldW-1:0] hot_bank_b;
    logic [RowW-1:0]     hot_base;
    logic [RowW-1:0]     r;
    wait_drained();
    write_limit(lim);
    sender_idle_pct = idle_pct;
    hot_vault = VaultW'($urandom);
    hot_bank_a = BankFldW'($urandom);
    hot_bank_b = BankFldW'($urandom);
    hot_base = RowW'($urandom);
    for (int k = 0; k < PhaseItems; k++) begin
      if (k == PhaseItems / 2) begin
        wait_drained();
      end
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          r = RowW'(hot_base + $urandom_range(0, 11));
        end else begin
          r = RowW'(hot_base + $urandom_range(0, 2));
        end
        send_access(hot_vault, $urandom_range(0, 1) ? hot_bank_a : hot_bank_b, r);
      end else begin
        send_access(VaultW'($urandom), BankFldW'($urandom), RowW'($urandom));
      end
    end
  endtask

  initial begin
    static logic [RowW-1:0] fill_rows [8] = '{13'd0, 13'd8191, 13'd1, 13'd2, 13'd4096,
                                              13'd5, 13'd6, 13'd7};
    rst_ni = 1'b0;
    start = 1'b0;
    vault_i = '0;
    bank_i = '0;
    row_i = '0;
    cfg_valid_i = 1'b0;
    tracked_limit_i = '0;
    sender_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill one table to capacity, hit one row, then miss to age out all but that row.
    write_limit(LimitReset);
    foreach (fill_rows[i]) send_access(0, 0, fill_rows[i]);
    send_access(0, 0, 8191);
    send_access(0, 0, 100);
    send_access(15, 7, 8191);

    // A zero limit never inserts; misses only age the table.
    wait_drained();
    write_limit(0);
    send_access(15, 7, 42);
    send_access(0, 0, 8191);

    // A limit above capacity acts as full capacity.
    wait_drained();
    write_limit(15);
    for (int i = 0; i < 8; i++) send_access(5, 2, RowW'(10 + i));
    send_access(5, 2, 10);
    send_access(5, 2, 11);
    send_access(5, 2, 18);

    // Lowering the limit below occupancy forces aging before the next insert.
    wait_drained();
    write_limit(1);
    send_access(5, 2, 19);
    send_access(5, 2, 19);

    run_phase(37, 3);
    run_phase(69, 8);
    run_phase(0, SmallW'($urandom_range(4, 15)));

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
